### rtl/core/itp_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// itp_pkg
// Shared types, constants and helpers of the infix to postfix converter.
// ----------------------------------------------------------------------------
package itp_pkg;

  localparam int STACK_DEPTH = 32;
  localparam int DEPTH_W     = $clog2(STACK_DEPTH + 1);
  localparam int ADDR_W      = $clog2(STACK_DEPTH);

  localparam logic [7:0] CH_MUL   = 8'h2A;
  localparam logic [7:0] CH_DIV   = 8'h2F;
  localparam logic [7:0] CH_ADD   = 8'h2B;
  localparam logic [7:0] CH_SUB   = 8'h2D;
  localparam logic [7:0] CH_OPEN  = 8'h28;
  localparam logic [7:0] CH_CLOSE = 8'h29;

  typedef enum logic [2:0] {
    OPC_NONE = 3'd0,
    OPC_OPEN = 3'd1,
    OPC_ADD  = 3'd2,
    OPC_SUB  = 3'd3,
    OPC_MUL  = 3'd4,
    OPC_DIV  = 3'd5
  } opc_t;

  typedef enum logic [1:0] {
    ST_OK              = 2'd0,
    ST_OVERFLOW        = 2'd1,
    ST_UNMATCHED_CLOSE = 2'd2,
    ST_UNMATCHED_OPEN  = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    KIND_ALNUM,
    KIND_OP,
    KIND_OPEN,
    KIND_CLOSE,
    KIND_OTHER
  } kind_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_WORK,
    S_END
  } state_t;

  function automatic opc_t char_opc(input logic [7:0] c);
    opc_t r;
    r = OPC_NONE;
    if (c == CH_ADD) r = OPC_ADD;
    else if (c == CH_SUB) r = OPC_SUB;
    else if (c == CH_MUL) r = OPC_MUL;
    else if (c == CH_DIV) r = OPC_DIV;
    return r;
  endfunction

  function automatic kind_t classify(input logic [7:0] c);
    kind_t k;
    k = KIND_OTHER;
    if ((c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h5A) ||
        (c >= 8'h61 && c <= 8'h7A)) k = KIND_ALNUM;
    else if (char_opc(c) != OPC_NONE) k = KIND_OP;
    else if (c == CH_OPEN) k = KIND_OPEN;
    else if (c == CH_CLOSE) k = KIND_CLOSE;
    return k;
  endfunction

  function automatic logic is_op(input opc_t o);
    return (o == OPC_ADD) || (o == OPC_SUB) || (o == OPC_MUL) || (o == OPC_DIV);
  endfunction

  function automatic logic [1:0] prec(input opc_t o);
    logic [1:0] p;
    p = 2'd0;
    if (o == OPC_MUL || o == OPC_DIV) p = 2'd2;
    else if (o == OPC_ADD || o == OPC_SUB) p = 2'd1;
    return p;
  endfunction

  function automatic logic [7:0] opc_char(input opc_t o);
    logic [7:0] c;
    case (o)
      OPC_OPEN: c = CH_OPEN;
      OPC_ADD:  c = CH_ADD;
      OPC_SUB:  c = CH_SUB;
      OPC_MUL:  c = CH_MUL;
      OPC_DIV:  c = CH_DIV;
      default:  c = 8'd0;
    endcase
    return c;
  endfunction

endpackage
`default_nettype wire

### rtl/core/itp_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// itp channel interfaces
// Valid/ready channels for input characters and postfix results.
// ----------------------------------------------------------------------------
interface itp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] ch;
  logic       end_of_expression;

  modport source (output valid, output ch, output end_of_expression, input ready);
  modport sink   (input valid, input ch, input end_of_expression, output ready);
endinterface

interface itp_out_if;
  logic                    valid;
  logic                    ready;
  logic [7:0]              out_char;
  logic                    terminator;
  itp_pkg::status_t        status;
  logic                    last;

  modport source (output valid, output out_char, output terminator, output status,
                  output last, input ready);
  modport sink   (input valid, input out_char, input terminator, input status,
                  input last, output ready);
endinterface
`default_nettype wire

### rtl/core/infix_to_postfix_converter_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// infix_to_postfix_converter_unit
// Shunting-yard infix to postfix conversion over an operator stack in RAM.
// ----------------------------------------------------------------------------
// a taken character is registered, then its first result is registered
// a new character is taken only when idle, after all pops for the last one;
//   an end mark also pops every remaining entry and then gives the terminator
// the stack ram has two registered read ports kept on the top two entries
// reset clears the stack depth and output valid; ram contents stay as they are
// ----------------------------------------------------------------------------
module infix_to_postfix_converter_unit (
  input  wire logic       clk,
  input  wire logic       rst_n,
  itp_in_if.sink          in_ch,
  itp_out_if.source       out_ch
);

  localparam int DW = itp_pkg::DEPTH_W;
  localparam int AW = itp_pkg::ADDR_W;

  itp_pkg::state_t state_r, state_nxt;
  logic [DW-1:0]   depth_r, depth_nxt;
  logic [7:0]      ch_r;
  logic            eoe_r;
  logic            open_left_r, open_left_nxt;

  itp_pkg::opc_t   stack_mem [itp_pkg::STACK_DEPTH];
  itp_pkg::opc_t   rd1_r, rd2_r;
  logic            we;
  itp_pkg::opc_t   wdata;
  logic [AW-1:0]   waddr;
  logic [AW-1:0]   rd1_addr, rd2_addr;

  logic             out_valid_r;
  logic [7:0]       out_char_r;
  logic             out_term_r;
  itp_pkg::status_t out_status_r;
  logic             out_last_r;

  logic             emit;
  logic [7:0]       e_char;
  logic             e_term;
  itp_pkg::status_t e_status;
  logic             e_last;

  itp_pkg::kind_t  kind;
  itp_pkg::opc_t   code;
  logic            can_emit;
  logic            has_top, has_sec, full;
  logic            op_pop, op_more, close_pop;
  itp_pkg::state_t fin_state;
  logic            in_acc;

  assign in_acc    = in_ch.valid && in_ch.ready;
  assign can_emit  = !out_valid_r || out_ch.ready;
  assign kind      = itp_pkg::classify(ch_r);
  assign code      = itp_pkg::char_opc(ch_r);
  assign has_top   = depth_r != '0;
  assign has_sec   = depth_r >= DW'(2);
  assign full      = depth_r == DW'(itp_pkg::STACK_DEPTH);
  assign op_pop    = has_top && itp_pkg::is_op(rd1_r) &&
                     (itp_pkg::prec(rd1_r) >= itp_pkg::prec(code));
  assign op_more   = has_sec && itp_pkg::is_op(rd2_r) &&
                     (itp_pkg::prec(rd2_r) >= itp_pkg::prec(code));
  assign close_pop = has_top && (rd1_r != itp_pkg::OPC_OPEN);
  assign fin_state = eoe_r ? itp_pkg::S_END : itp_pkg::S_IDLE;

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      itp_pkg::S_IDLE: begin
        if (in_acc) state_nxt = itp_pkg::S_WORK;
      end
      itp_pkg::S_WORK: begin
        case (kind)
          itp_pkg::KIND_ALNUM: begin
            if (can_emit) state_nxt = fin_state;
          end
          itp_pkg::KIND_OP: begin
            if (!op_pop && (!full || can_emit)) state_nxt = fin_state;
          end
          itp_pkg::KIND_OPEN: begin
            if (!full || can_emit) state_nxt = fin_state;
          end
          itp_pkg::KIND_CLOSE: begin
            if (!close_pop && (has_top || can_emit)) state_nxt = fin_state;
          end
          default: state_nxt = fin_state;
        endcase
      end
      itp_pkg::S_END: begin
        if (!has_top && can_emit) state_nxt = itp_pkg::S_IDLE;
      end
      default: state_nxt = itp_pkg::S_IDLE;
    endcase
  end

  // datapath and result selection
  always_comb begin
    emit          = 1'b0;
    e_char        = 8'd0;
    e_term        = 1'b0;
    e_status      = itp_pkg::ST_OK;
    e_last        = 1'b0;
    depth_nxt     = depth_r;
    we            = 1'b0;
    wdata         = code;
    open_left_nxt = open_left_r;
    unique case (state_r)
      itp_pkg::S_IDLE: begin
        if (in_acc) open_left_nxt = 1'b0;
      end
      itp_pkg::S_WORK: begin
        case (kind) inside
          itp_pkg::KIND_ALNUM: begin
            emit   = 1'b1;
            e_char = ch_r;
            e_last = !eoe_r;
          end
          itp_pkg::KIND_OP, itp_pkg::KIND_OPEN: begin
            if (kind == itp_pkg::KIND_OP && op_pop) begin
              emit   = 1'b1;
              e_char = itp_pkg::opc_char(rd1_r);
              e_last = !eoe_r && !op_more;
              if (can_emit) depth_nxt = depth_r - DW'(1);
            end else if (!full) begin
              we        = 1'b1;
              wdata     = (kind == itp_pkg::KIND_OP) ? code : itp_pkg::OPC_OPEN;
              depth_nxt = depth_r + DW'(1);
            end else begin
              emit     = 1'b1;
              e_status = itp_pkg::ST_OVERFLOW;
              e_last   = !eoe_r;
            end
          end
          itp_pkg::KIND_CLOSE: begin
            if (close_pop) begin
              emit   = 1'b1;
              e_char = itp_pkg::opc_char(rd1_r);
              e_last = !eoe_r && has_sec && (rd2_r == itp_pkg::OPC_OPEN);
              if (can_emit) depth_nxt = depth_r - DW'(1);
            end else if (has_top) begin
              depth_nxt = depth_r - DW'(1);
            end else begin
              emit     = 1'b1;
              e_status = itp_pkg::ST_UNMATCHED_CLOSE;
              e_last   = !eoe_r;
            end
          end
          default: ;
        endcase
      end
      itp_pkg::S_END: begin
        if (has_top) begin
          if (rd1_r == itp_pkg::OPC_OPEN) begin
            open_left_nxt = 1'b1;
            depth_nxt     = depth_r - DW'(1);
          end else begin
            emit   = 1'b1;
            e_char = itp_pkg::opc_char(rd1_r);
            if (can_emit) depth_nxt = depth_r - DW'(1);
          end
        end else begin
          emit     = 1'b1;
          e_term   = 1'b1;
          e_status = open_left_r ? itp_pkg::ST_UNMATCHED_OPEN : itp_pkg::ST_OK;
          e_last   = 1'b1;
        end
      end
      default: ;
    endcase
  end

  // read ports track the top two entries of the next depth
  assign rd1_addr = depth_nxt[AW-1:0] - AW'(1);
  assign rd2_addr = depth_nxt[AW-1:0] - AW'(2);
  assign waddr    = depth_r[AW-1:0];

  always_ff @(posedge clk) begin
    if (we) stack_mem[waddr] <= wdata;
    rd1_r <= (we && waddr == rd1_addr) ? wdata : stack_mem[rd1_addr];
    rd2_r <= (we && waddr == rd2_addr) ? wdata : stack_mem[rd2_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= itp_pkg::S_IDLE;
      depth_r     <= '0;
      open_left_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      depth_r     <= depth_nxt;
      open_left_r <= open_left_nxt;
      if (can_emit) out_valid_r <= emit;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      ch_r  <= in_ch.ch;
      eoe_r <= in_ch.end_of_expression;
    end
    if (emit && can_emit) begin
      out_char_r   <= e_char;
      out_term_r   <= e_term;
      out_status_r <= e_status;
      out_last_r   <= e_last;
    end
  end

  assign in_ch.ready       = state_r == itp_pkg::S_IDLE;
  assign out_ch.valid      = out_valid_r;
  assign out_ch.out_char   = out_char_r;
  assign out_ch.terminator = out_term_r;
  assign out_ch.status     = out_status_r;
  assign out_ch.last       = out_last_r;

endmodule
`default_nettype wire

### rtl/core/itp_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// itp_checker
// Port-level checks of the converter, bound to the top level.
// ----------------------------------------------------------------------------
module itp_checker (
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       in_valid,
  input wire logic       in_ready,
  input wire logic       out_valid,
  input wire logic       out_ready,
  input wire logic [7:0] out_char,
  input wire logic       out_last
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_char) && $stable(out_last))
    else $error("result changed while stalled");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("second transaction taken while one is at work");

  a_no_take_midstream: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last |-> !in_ready)
    else $error("input taken before all results of a transaction");

endmodule

bind infix_to_postfix_converter_unit itp_checker u_itp_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_char  (out_ch.out_char),
  .out_last  (out_ch.last)
);
`default_nettype wire

### tb/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Checks the infix to postfix converter against a shunting-yard predictor
// kept in the bench. Directed expressions cover operand and operator
// characters, precedence, parentheses, end marks and the status cases.
// Random well-formed expressions follow, mixed with broken ones and stray
// bytes, under random gaps on both channels and one long result hold-off.
// ----------------------------------------------------------------------------
module testbench;

  localparam int unsigned HOLD_CYCLES  = 200;
  localparam int unsigned DRAIN_CYCLES = 80;
  localparam int unsigned RUN_LIMIT    = 8_000_000;

  typedef struct packed {
    logic [7:0]       out_char;
    logic             terminator;
    itp_pkg::status_t status;
    logic             last;
  } postfix_sym_t;

  logic clk;
  logic rst_n;

  itp_in_if  in_if ();
  itp_out_if out_if ();

  infix_to_postfix_converter_unit u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_if),
    .out_ch (out_if)
  );

  postfix_sym_t  postfix_expect[$];
  itp_pkg::opc_t op_shadow[itp_pkg::STACK_DEPTH];
  int unsigned   shadow_depth;
  logic [7:0]    expr_chars[$];
  int unsigned   idle_pct;
  int unsigned   tokens_sent;
  bit            hold_request;
  bit            mismatch_seen;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #(RUN_LIMIT);
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // shunting-yard predictor
  function automatic bit is_operand(input logic [7:0] c);
    return (c >= "0" && c <= "9") || (c >= "A" && c <= "Z") || (c >= "a" && c <= "z");
  endfunction

  function automatic itp_pkg::opc_t op_of(input logic [7:0] c);
    case (c)
      itp_pkg::CH_ADD: return itp_pkg::OPC_ADD;
      itp_pkg::CH_SUB: return itp_pkg::OPC_SUB;
      itp_pkg::CH_MUL: return itp_pkg::OPC_MUL;
      itp_pkg::CH_DIV: return itp_pkg::OPC_DIV;
      default:         return itp_pkg::OPC_NONE;
    endcase
  endfunction

  function automatic int unsigned binding(input itp_pkg::opc_t o);
    if (o == itp_pkg::OPC_MUL || o == itp_pkg::OPC_DIV) return 2;
    if (o == itp_pkg::OPC_ADD || o == itp_pkg::OPC_SUB) return 1;
    return 0;
  endfunction

  function automatic logic [7:0] symbol_of(input itp_pkg::opc_t o);
    case (o)
      itp_pkg::OPC_ADD: return itp_pkg::CH_ADD;
      itp_pkg::OPC_SUB: return itp_pkg::CH_SUB;
      itp_pkg::OPC_MUL: return itp_pkg::CH_MUL;
      itp_pkg::OPC_DIV: return itp_pkg::CH_DIV;
      default:          return 8'h00;
    endcase
  endfunction

  function automatic bit is_token(input logic [7:0] c);
    return is_operand(c) || op_of(c) != itp_pkg::OPC_NONE ||
           c == itp_pkg::CH_OPEN || c == itp_pkg::CH_CLOSE;
  endfunction

  task automatic note_result(input logic [7:0] c, input logic term,
                             input itp_pkg::status_t st);
    postfix_sym_t s;
    s.out_char   = c;
    s.terminator = term;
    s.status     = st;
    s.last       = 1'b0;
    postfix_expect.push_back(s);
  endtask

  task automatic push_op(input itp_pkg::opc_t code);
    if (shadow_depth < itp_pkg::STACK_DEPTH) begin
      op_shadow[shadow_depth] = code;
      shadow_depth++;
    end else begin
      note_result(8'h00, 1'b0, itp_pkg::ST_OVERFLOW);
    end
  endtask

  task automatic convert_char(input logic [7:0] c, input logic eoe);
    int unsigned   first;
    itp_pkg::opc_t code;
    logic          open_left;
    first = postfix_expect.size();
    code  = op_of(c);
    if (is_operand(c)) begin
      note_result(c, 1'b0, itp_pkg::ST_OK);
    end else if (code != itp_pkg::OPC_NONE) begin
      while (shadow_depth > 0 && op_shadow[shadow_depth-1] != itp_pkg::OPC_OPEN &&
             binding(op_shadow[shadow_depth-1]) >= binding(code)) begin
        note_result(symbol_of(op_shadow[shadow_depth-1]), 1'b0, itp_pkg::ST_OK);
        shadow_depth--;
      end
      push_op(code);
    end else if (c == itp_pkg::CH_OPEN) begin
      push_op(itp_pkg::OPC_OPEN);
    end else if (c == itp_pkg::CH_CLOSE) begin
      while (shadow_depth > 0 && op_shadow[shadow_depth-1] != itp_pkg::OPC_OPEN) begin
        note_result(symbol_of(op_shadow[shadow_depth-1]), 1'b0, itp_pkg::ST_OK);
        shadow_depth--;
      end
      if (shadow_depth > 0) shadow_depth--;
      else note_result(8'h00, 1'b0, itp_pkg::ST_UNMATCHED_CLOSE);
    end
    if (eoe) begin
      open_left = 1'b0;
      while (shadow_depth > 0) begin
        shadow_depth--;
        if (op_shadow[shadow_depth] == itp_pkg::OPC_OPEN) open_left = 1'b1;
        else note_result(symbol_of(op_shadow[shadow_depth]), 1'b0, itp_pkg::ST_OK);
      end
      note_result(8'h00, 1'b1,
                  open_left ? itp_pkg::ST_UNMATCHED_OPEN : itp_pkg::ST_OK);
    end
    if (postfix_expect.size() > first)
      postfix_expect[postfix_expect.size()-1].last = 1'b1;
  endtask

  // mostly short gaps, a few long ones
  function automatic int unsigned pick_gap();
    if (idle_pct == 0 || $urandom_range(99) >= idle_pct) return 0;
    if ($urandom_range(9) == 0) return $urandom_range(40, 12);
    return $urandom_range(3, 1);
  endfunction

  // called at a falling edge, returns at the falling edge after acceptance
  task automatic send_char(input logic [7:0] c, input logic eoe);
    int unsigned gap;
    gap = pick_gap();
    if (gap != 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_if.valid             <= 1'b1;
    in_if.ch                <= c;
    in_if.end_of_expression <= eoe;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
    convert_char(c, eoe);
    if (is_token(c) || eoe) tokens_sent++;
    @(negedge clk);
  endtask

  task automatic send_string(input string s, input bit end_mark);
    for (int i = 0; i < s.len(); i++)
      send_char(s[i], end_mark && i == s.len() - 1);
  endtask

  // result sink: random stalls plus a long hold-off on request
  initial begin
    int unsigned stall_left;
    stall_left   = 0;
    out_if.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (stall_left != 0) begin
        out_if.ready <= 1'b0;
        stall_left--;
      end else if (hold_request) begin
        hold_request = 1'b0;
        out_if.ready <= 1'b0;
        stall_left = HOLD_CYCLES - 1;
      end else begin
        stall_left = pick_gap();
        if (stall_left != 0) begin
          out_if.ready <= 1'b0;
          stall_left--;
        end else begin
          out_if.ready <= 1'b1;
        end
      end
    end
  end

  task automatic check_field(input string name, input int unsigned want,
                             input int unsigned got);
    if (want != got) begin
      $display("%0t: %s expected %0h actual %0h", $time, name, want, got);
      mismatch_seen = 1'b1;
    end
  endtask

  // result checker
  always @(posedge clk) begin
    postfix_sym_t want;
    if (rst_n && out_if.valid && out_if.ready) begin
      if (postfix_expect.size() == 0) begin
        $display("%0t: unexpected transaction expected none actual char %0h term %0b",
                 $time, out_if.out_char, out_if.terminator);
        mismatch_seen = 1'b1;
      end else begin
        want = postfix_expect.pop_front();
        check_field("out_char", want.out_char, out_if.out_char);
        check_field("terminator", want.terminator, out_if.terminator);
        check_field("status", want.status, out_if.status);
        check_field("last", want.last, out_if.last);
      end
    end
  end

  function automatic logic [7:0] rand_operand();
    int unsigned r;
    r = $urandom_range(61);
    if (r < 10) return 8'(r) + "0";
    if (r < 36) return 8'(r - 10) + "A";
    return 8'(r - 36) + "a";
  endfunction

  function automatic logic [7:0] rand_operator();
    case ($urandom_range(3))
      0:       return itp_pkg::CH_ADD;
      1:       return itp_pkg::CH_SUB;
      2:       return itp_pkg::CH_MUL;
      default: return itp_pkg::CH_DIV;
    endcase
  endfunction

  task automatic build_expression();
    int unsigned terms;
    int unsigned open_cnt;
    int unsigned nest_cap;
    expr_chars.delete();
    terms    = $urandom_range(8, 1);
    nest_cap = ($urandom_range(19) == 0) ? 36 : 6;
    open_cnt = 0;
    for (int i = 0; i < terms; i++) begin
      while (open_cnt < nest_cap && $urandom_range(3) == 0) begin
        expr_chars.push_back(itp_pkg::CH_OPEN);
        open_cnt++;
      end
      expr_chars.push_back(rand_operand());
      while (open_cnt > 0 && $urandom_range(2) == 0) begin
        expr_chars.push_back(itp_pkg::CH_CLOSE);
        open_cnt--;
      end
      if (i != terms - 1) expr_chars.push_back(rand_operator());
    end
    while (open_cnt > 0) begin
      expr_chars.push_back(itp_pkg::CH_CLOSE);
      open_cnt--;
    end
  endtask

  task automatic break_expression();
    int unsigned idx;
    idx = $urandom_range(expr_chars.size() - 1);
    case ($urandom_range(3))
      0: if (expr_chars.size() > 1) expr_chars.delete(idx);
      1: expr_chars.insert(idx, 8'($urandom_range(255)));
      2: expr_chars.insert(idx, itp_pkg::CH_CLOSE);
      default: expr_chars.insert(idx, itp_pkg::CH_OPEN);
    endcase
  endtask

  task automatic test_operands();
    send_string("09AZa", 1'b0);
    send_char(8'hFF, 1'b1);
  endtask

  task automatic test_precedence();
    send_string("z-y*x/w+v", 1'b1);
  endtask

  task automatic test_parentheses();
    send_string("(b+c)*d", 1'b1);
  endtask

  task automatic test_unmatched_parens();
    send_char(itp_pkg::CH_CLOSE, 1'b1);
    send_char(itp_pkg::CH_OPEN, 1'b1);
    send_char(itp_pkg::CH_ADD, 1'b1);
  endtask

  task automatic test_stack_overflow();
    repeat (itp_pkg::STACK_DEPTH - 1) send_char(itp_pkg::CH_OPEN, 1'b0);
    send_string("a+*()", 1'b0);
    send_char("b", 1'b1);
  endtask

  task automatic test_output_backpressure();
    hold_request = 1'b1;
    repeat (40) send_char(rand_operand(), 1'b0);
    send_string("+q", 1'b1);
  endtask

  task automatic test_random_stream(input int unsigned target);
    int unsigned kind;
    int unsigned n;
    while (tokens_sent < target) begin
      kind = $urandom_range(99);
      if (kind < 8) begin
        n = $urandom_range(3, 1);
        for (int i = 0; i < n; i++)
          send_char(8'($urandom_range(255)), i == n - 1 && $urandom_range(1) == 1);
      end else begin
        build_expression();
        if (kind < 25) break_expression();
        foreach (expr_chars[i])
          send_char(expr_chars[i], i == expr_chars.size() - 1);
      end
    end
  endtask

  initial begin
    rst_n                   = 1'b0;
    in_if.valid             = 1'b0;
    in_if.ch                = 8'h00;
    in_if.end_of_expression = 1'b0;
    shadow_depth            = 0;
    tokens_sent             = 0;
    hold_request            = 1'b0;
    mismatch_seen           = 1'b0;
    idle_pct                = 30;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_operands();
    test_precedence();
    test_parentheses();
    test_unmatched_parens();
    test_stack_overflow();
    test_random_stream(tokens_sent + 110);
    idle_pct = 0;
    test_random_stream(tokens_sent + 80);
    idle_pct = 30;
    test_output_backpressure();
    test_random_stream(tokens_sent + 120);
    in_if.valid <= 1'b0;

    while (postfix_expect.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (!mismatch_seen) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

### filelist.f
rtl/core/itp_pkg.sv
rtl/core/itp_if.sv
rtl/core/infix_to_postfix_converter_unit.sv
rtl/core/itp_checker.sv
tb/testbench.sv
